/* hw/rtl/sliding_window_rate_limiter_defines.svh */
// assertion macros for the rate limiter
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define SWRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate limiter check failed");

// next-cycle implication, sampled on clk, idle during reset
`define SWRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate limiter check failed");

`endif

/* hw/rtl/swrl_pkg.sv */
`timescale 1ns / 1ps

package swrl_pkg;

    localparam int TIME_W    = 32;
    localparam int WIN_W     = 16;
    localparam int MAXREQ_W  = 7;
    localparam int OUT_CNT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'b1;

    localparam logic [WIN_W-1:0]    WINDOW_RESET = 16'd60;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 7'd60;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } swrl_state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic commit;
    } swrl_cmd_t;

    typedef struct packed {
        logic nonempty;
        logic expired;
    } swrl_status_t;

endpackage

/* hw/rtl/swrl_req_if.sv */
`timescale 1ns / 1ps

interface swrl_req_if
    import swrl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output now_time, input ready);
    modport sink (input valid, input now_time, output ready);
endinterface

/* hw/rtl/swrl_rsp_if.sv */
`timescale 1ns / 1ps

interface swrl_rsp_if
    import swrl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 allowed;
    logic [OUT_CNT_W-1:0] in_window;

    modport source (output valid, output allowed, output in_window, input ready);
    modport sink (input valid, input allowed, input in_window, output ready);
endinterface

/* hw/rtl/swrl_ram.sv */
`timescale 1ns / 1ps

module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/swrl_datapath.sv */
`timescale 1ns / 1ps

module swrl_datapath
    import swrl_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [TIME_W-1:0]     now_time,
    input  swrl_cmd_t             cmd,
    output swrl_status_t          status,
    output logic                  allowed,
    output logic [OUT_CNT_W-1:0]  in_window
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int LIM_W = (CNT_W > MAXREQ_W) ? CNT_W : MAXREQ_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(STORE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(STORE_DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(STORE_DEPTH);

    logic [WIN_W-1:0]     window_reg;
    logic [MAXREQ_W-1:0]  max_req_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]    now_reg;
    logic                 allowed_reg;
    logic [OUT_CNT_W-1:0] in_window_reg;

    logic [TIME_W-1:0]    head_stamp;
    logic [TIME_W-1:0]    age;
    logic [IDX_W-1:0]     head_inc;
    logic [SUM_W-1:0]     tail_sum;
    logic [IDX_W-1:0]     tail;
    logic [LIM_W-1:0]     maxreq_ext;
    logic [LIM_W-1:0]     limit;
    logic                 below_limit;
    logic                 admit;

    always_comb
    begin
        age        = now_reg - head_stamp;
        head_inc   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        tail_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail       = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                             : IDX_W'(tail_sum);
        maxreq_ext = LIM_W'(max_req_reg);
        limit      = (maxreq_ext > DEPTH_LIM) ? DEPTH_LIM : maxreq_ext;
        below_limit = LIM_W'(count_reg) < limit;
        admit      = cmd.commit && below_limit;

        status.nonempty = (count_reg != '0);
        status.expired  = (count_reg != '0) && (age >= TIME_W'(window_reg));

        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        else if (admit)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // read address follows the next head, so the registered read output holds the oldest stamp in step with head_reg
    swrl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (admit),
        .wr_addr (tail),
        .wr_data (now_reg),
        .rd_addr (head_next),
        .rd_data (head_stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            max_req_reg <= MAXREQ_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_TICKS: window_reg  <= cfg_data[WIN_W-1:0];
                    CFG_MAX_REQUESTS: max_req_reg <= cfg_data[MAXREQ_W-1:0];
                    default: ;
                endcase
            end
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_time;
        end
        if (cmd.commit)
        begin
            allowed_reg   <= below_limit;
            in_window_reg <= OUT_CNT_W'(count_next);
        end
    end

    assign allowed   = allowed_reg;
    assign in_window = in_window_reg;

endmodule

/* hw/rtl/swrl_ctrl.sv */
`timescale 1ns / 1ps

module swrl_ctrl
    import swrl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  swrl_status_t status,
    output swrl_cmd_t    cmd
);

    swrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        in_ready       = (state_reg == ST_IDLE);
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.expired)
                begin
                    cmd.pop = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/sliding_window_rate_limiter.sv */
// request path: IDLE loads the request stamp, CHECK pops each expired stamp at the store head,
//   then commits once the result register is free; a new request is taken only back in IDLE;
//   the single read port of the stamp store sets the pop rate
// the result register frees the request side while a result waits
// reset: asynchronous active low; empty store, window 60, limit 60
`timescale 1ns / 1ps

`include "sliding_window_rate_limiter_defines.svh"

module sliding_window_rate_limiter
    import swrl_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    swrl_req_if.sink              req,
    swrl_rsp_if.source            rsp
);

    swrl_cmd_t    cmd;
    swrl_status_t status;

    swrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    swrl_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .now_time  (req.now_time),
        .cmd       (cmd),
        .status    (status),
        .allowed   (rsp.allowed),
        .in_window (rsp.in_window)
    );

    `SWRL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `SWRL_ASSERT_NOW(a_pop_nonempty, cmd.pop, status.nonempty)
    `SWRL_ASSERT_NOW(a_pop_commit_excl, cmd.pop, !cmd.commit && !cmd.load)
    `SWRL_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp.valid && !req.ready == 1'b0)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import swrl_pkg::*;

    localparam int STORE_DEPTH = 64;

    typedef enum logic {
        ENTRY_REQ,
        ENTRY_CFG
    } entry_kind_t;

    typedef struct {
        entry_kind_t           kind;
        logic [TIME_W-1:0]     stamp;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic                 allowed;
        logic [OUT_CNT_W-1:0] in_window;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    swrl_req_if req ();
    swrl_rsp_if rsp ();

    sliding_window_rate_limiter #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    // shadow of the limiter state
    logic [TIME_W-1:0]   stamp_log [STORE_DEPTH];
    logic [5:0]          log_head;
    logic [6:0]          log_count;
    logic [WIN_W-1:0]    window_shadow;
    logic [MAXREQ_W-1:0] limit_shadow;

    entry_t   pending_q [$];
    verdict_t verdict_q [$];

    int errors;
    int requests_sent;
    int results_seen;
    int admitted;
    int refused;
    int config_writes;
    int peak_in_window;
    int quiet_cycles;
    int hold_left;
    logic hold_done;

    logic   drive_valid;
    logic   drive_we;
    entry_t head_entry;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void push_req(input logic [TIME_W-1:0] stamp);
        entry_t e;
        e.kind = ENTRY_REQ;
        e.stamp = stamp;
        e.idx = '0;
        e.data = '0;
        pending_q.push_back(e);
    endfunction

    function automatic void push_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        entry_t e;
        e.kind = ENTRY_CFG;
        e.stamp = '0;
        e.idx = idx;
        e.data = data;
        pending_q.push_back(e);
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WINDOW_TICKS)
            window_shadow = data[WIN_W-1:0];
        else if (idx == CFG_MAX_REQUESTS)
            limit_shadow = data[MAXREQ_W-1:0];
    endfunction

    function automatic void predict_admission(input logic [TIME_W-1:0] now);
        logic [6:0]        limit;
        logic [TIME_W-1:0] age;
        logic [5:0]        tail;
        verdict_t          v;
        limit = (limit_shadow > 7'(STORE_DEPTH)) ? 7'(STORE_DEPTH) : limit_shadow;
        // expire from the head until the first stamp still inside the window
        while (log_count != 0)
        begin
            age = now - stamp_log[log_head];
            if (age < {16'd0, window_shadow})
                break;
            log_head = log_head + 6'd1;
            log_count = log_count - 7'd1;
        end
        v.allowed = 1'b0;
        if (log_count < limit)
        begin
            tail = log_head + log_count[5:0];
            stamp_log[tail] = now;
            log_count = log_count + 7'd1;
            v.allowed = 1'b1;
        end
        v.in_window = log_count;
        verdict_q.push_back(v);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.now_time <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            quiet_cycles = 0;
        end
        else
        begin
            drive_valid = req.valid;
            drive_we = 1'b0;
            if (req.valid && req.ready)
            begin
                predict_admission(req.now_time);
                requests_sent++;
                drive_valid = 1'b0;
            end
            quiet_cycles = (verdict_q.size() == 0 && !drive_valid) ? quiet_cycles + 1 : 0;
            if (!drive_valid && pending_q.size() != 0)
            begin
                if (pending_q[0].kind == ENTRY_CFG)
                begin
                    // registers only change with nothing in flight
                    if (quiet_cycles >= 4)
                    begin
                        head_entry = pending_q.pop_front();
                        drive_we = 1'b1;
                        cfg_index <= head_entry.idx;
                        cfg_data <= head_entry.data;
                        apply_config(head_entry.idx, head_entry.data);
                        config_writes++;
                        quiet_cycles = 0;
                    end
                end
                else if ((requests_sent >= 150 && requests_sent < 300) || hold_left != 0
                         || $urandom_range(0, 99) >= 36)
                begin
                    head_entry = pending_q.pop_front();
                    drive_valid = 1'b1;
                    req.now_time <= head_entry.stamp;
                end
            end
            req.valid <= drive_valid;
            cfg_we <= drive_we;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (rsp.allowed)
                    admitted++;
                else
                    refused++;
                if (int'(rsp.in_window) > peak_in_window)
                    peak_in_window = int'(rsp.in_window);
                if (verdict_q.size() == 0)
                    report_mismatch("result transaction with nothing expected, in_window",
                                    int'(rsp.in_window), -1);
                else
                begin
                    if (rsp.allowed !== verdict_q[0].allowed)
                        report_mismatch("allowed", int'(rsp.allowed),
                                        int'(verdict_q[0].allowed));
                    if (rsp.in_window !== verdict_q[0].in_window)
                        report_mismatch("in_window", int'(rsp.in_window),
                                        int'(verdict_q[0].in_window));
                    void'(verdict_q.pop_front());
                end
            end
            if (hold_left != 0)
                rsp.ready <= 1'b0;
            else if (results_seen >= 100 && results_seen < 200)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 99) >= 36);
        end
    end

    // one long back-pressure stretch on the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 230)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin
        #3_000_000;
        $display("sliding_window_rate_limiter verification failed");
        $finish;
    end

    initial
    begin
        int random_items;
        int phase;
        int phase_kind;
        int phase_len;
        int spread;
        int k;
        logic [TIME_W-1:0]     stamp;
        logic [WIN_W-1:0]      win_sel;
        logic [MAXREQ_W-1:0]   lim_sel;
        logic [CFG_DATA_W-1:0] cfg_val;

        req.valid = 1'b0;
        req.now_time = '0;
        rsp.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        admitted = 0;
        refused = 0;
        config_writes = 0;
        peak_in_window = 0;
        window_shadow = WINDOW_RESET;
        limit_shadow = MAXREQ_RESET;
        log_head = '0;
        log_count = '0;

        // reset values of window and limit
        push_req(32'd100);
        push_req(32'd100);
        push_req(32'd159);
        push_req(32'd160);
        // small window, tight limit, a stamp out of order
        push_cfg(CFG_WINDOW_TICKS, 16'd10);
        push_cfg(CFG_MAX_REQUESTS, 16'd3);
        push_req(32'd200);
        push_req(32'd201);
        push_req(32'd202);
        push_req(32'd203);
        push_req(32'd209);
        push_req(32'd210);
        push_req(32'd205);
        // time stamp wrap
        push_req(32'hFFFF_FFF8);
        push_req(32'hFFFF_FFFF);
        push_req(32'h0000_0000);
        push_req(32'h0000_0003);
        // zero window
        push_cfg(CFG_WINDOW_TICKS, 16'd0);
        push_req(32'd5);
        push_req(32'd5);
        // zero limit
        push_cfg(CFG_MAX_REQUESTS, 16'd0);
        push_req(32'd6);
        // limit above depth, widest window
        push_cfg(CFG_WINDOW_TICKS, 16'hFFFF);
        push_cfg(CFG_MAX_REQUESTS, 16'd127);
        push_req(32'd7);
        push_req(32'd7);
        // junk above the limit field
        push_cfg(CFG_MAX_REQUESTS, 16'hFF82);
        push_req(32'd8);
        push_req(32'd9);

        stamp = $urandom;
        random_items = 0;
        phase = 0;
        while (random_items < 400)
        begin
            phase_kind = (phase == 0) ? 2 : int'($urandom_range(0, 5));
            phase_len = int'($urandom_range(20, 50));
            case (phase_kind)
                0:
                begin
                    win_sel = WIN_W'($urandom_range(1, 200));
                    lim_sel = MAXREQ_W'($urandom_range(1, 64));
                end
                1:
                begin
                    win_sel = WIN_W'($urandom_range(0, 1));
                    lim_sel = MAXREQ_W'($urandom_range(0, 127));
                end
                2:
                begin
                    // fill the whole store
                    win_sel = 16'hFFFF;
                    lim_sel = MAXREQ_W'($urandom_range(65, 127));
                    phase_len = 70;
                end
                3:
                begin
                    win_sel = WIN_W'($urandom);
                    lim_sel = MAXREQ_W'($urandom_range(0, 127));
                end
                4:
                begin
                    win_sel = WIN_W'($urandom_range(1, 50));
                    lim_sel = 7'd64;
                end
                default:
                begin
                    win_sel = WIN_W'($urandom);
                    lim_sel = 7'd0;
                end
            endcase
            cfg_val = CFG_DATA_W'($urandom);
            cfg_val[MAXREQ_W-1:0] = lim_sel;
            push_cfg(CFG_WINDOW_TICKS, win_sel);
            push_cfg(CFG_MAX_REQUESTS, cfg_val);
            spread = (2 * int'(win_sel)) / ((lim_sel == 0) ? 1 : int'(lim_sel)) + 1;
            for (k = 0; k < phase_len; k++)
            begin
                if (phase_kind == 2)
                    stamp = stamp;
                else if ($urandom_range(0, 19) == 0)
                    stamp = stamp + $urandom;
                else if ($urandom_range(0, 29) == 0)
                    stamp = stamp - $urandom_range(1, int'(win_sel) + 1);
                else
                    stamp = stamp + $urandom_range(0, spread);
                push_req(stamp);
            end
            // jump past the window so the full store drains in one request
            if (phase_kind == 2)
                stamp = stamp + 32'h0001_0000;
            random_items += phase_len;
            phase++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch("results still awaited", 0, verdict_q.size());

        $display("%0d requests checked (%0d admitted, %0d refused), %0d register writes",
                 results_seen, admitted, refused, config_writes);
        $display("fullest window seen %0d, %0d mismatches", peak_in_window, errors);
        if (errors == 0)
            $display("sliding_window_rate_limiter verification clean");
        else
            $display("sliding_window_rate_limiter verification failed");
        $finish;
    end

endmodule
